FILE: rtl/scdv_pkg.sv
package scdv_pkg;

  // ASCII codes that the validator recognises.
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharHyphen = 8'h2D;
  localparam logic [7:0] CharSpace  = 8'h20;

  // Digit positions: nine weighted body digits, then two control digits.
  localparam logic [3:0] BodyDigits  = 4'd9;
  localparam logic [3:0] TotalDigits = 4'd11;
  localparam logic [3:0] RunCeiling  = 4'd9;
  localparam logic [3:0] RunReset    = 4'd2;

  // Control value arithmetic.
  localparam logic [8:0] CheckMod  = 9'd101;
  localparam logic [6:0] CheckWrap = 7'd100;
  localparam logic [8:0] MaxSum    = 9'd405;

  typedef enum logic [1:0] {
    FAULT_NONE      = 2'd0,
    FAULT_REPEAT    = 2'd1,
    FAULT_MISMATCH  = 2'd2,
    FAULT_MALFORMED = 2'd3
  } fault_e;

  typedef struct packed {
    logic [3:0] digit_count;
    logic [8:0] weighted_sum;
    logic [3:0] previous_digit;
    logic [3:0] run_length;
    logic       repeat_fault;
    logic       malformed_flag;
    logic [3:0] control_high_digit;
    logic [3:0] control_low_digit;
  } number_state_t;

endpackage

FILE: rtl/scdv_accum.sv
module scdv_accum (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              char_i,
  input  logic                    last_i,
  input  logic [3:0]              max_run_i,
  output scdv_pkg::number_state_t state_o
);

  scdv_pkg::number_state_t state_q, state_d, upd;

  logic       is_digit;
  logic [3:0] digit;
  logic [3:0] weight;
  logic [7:0] product;
  logic [3:0] run_next;

  assign is_digit = (char_i >= scdv_pkg::CharZero) && (char_i <= scdv_pkg::CharNine);
  assign digit    = char_i[3:0];
  assign weight   = scdv_pkg::BodyDigits - state_q.digit_count;
  assign product  = weight * digit;

  always_comb begin
    upd = state_q;
    run_next = 4'd1;
    if (is_digit) begin
      if (state_q.digit_count < scdv_pkg::BodyDigits) begin
        upd.weighted_sum = state_q.weighted_sum + {1'b0, product};
        if ((state_q.digit_count != 4'd0) && (digit == state_q.previous_digit)) begin
          run_next = (state_q.run_length < scdv_pkg::RunCeiling) ?
                     state_q.run_length + 4'd1 : state_q.run_length;
        end
        upd.run_length = run_next;
        if (run_next >= max_run_i) begin
          upd.repeat_fault = 1'b1;
        end
        upd.previous_digit = digit;
      end else if (state_q.digit_count == scdv_pkg::BodyDigits) begin
        upd.control_high_digit = digit;
      end else if (state_q.digit_count == scdv_pkg::BodyDigits + 4'd1) begin
        upd.control_low_digit = digit;
      end
      if (state_q.digit_count < scdv_pkg::TotalDigits) begin
        upd.digit_count = state_q.digit_count + 4'd1;
      end
    end else if ((char_i != scdv_pkg::CharHyphen) && (char_i != scdv_pkg::CharSpace)) begin
      upd.malformed_flag = 1'b1;
    end
  end

  // The verdict sees the state with the marked character already applied.
  assign state_o = upd;

  always_comb begin
    state_d = state_q;
    if (step_i) begin
      state_d = last_i ? '0 : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> (state_q.digit_count == 4'd0) && (state_q.weighted_sum == 9'd0))
    else $error("number state not cleared after the last item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.digit_count <= scdv_pkg::TotalDigits)
    else $error("digit count beyond eleven");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.weighted_sum <= scdv_pkg::MaxSum)
    else $error("weighted sum out of range");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run_length <= scdv_pkg::RunCeiling)
    else $error("run length out of range");

endmodule

FILE: rtl/scdv_verdict.sv
module scdv_verdict (
  input  scdv_pkg::number_state_t state_i,
  output scdv_pkg::fault_e        fault_o
);

  logic [8:0] s;
  logic [8:0] rem_full;
  logic [6:0] rem;
  logic [6:0] control_value;
  logic [6:0] control_pair;

  assign s = state_i.weighted_sum;

  // The sum never exceeds 405, so at most four subtractions of the modulus.
  always_comb begin
    priority if (s >= 9'd404) begin
      rem_full = s - 9'd404;
    end else if (s >= 9'd303) begin
      rem_full = s - 9'd303;
    end else if (s >= 9'd202) begin
      rem_full = s - 9'd202;
    end else if (s >= scdv_pkg::CheckMod) begin
      rem_full = s - scdv_pkg::CheckMod;
    end else begin
      rem_full = s;
    end
  end

  assign rem           = rem_full[6:0];
  assign control_value = (rem == scdv_pkg::CheckWrap) ? 7'd0 : rem;
  assign control_pair  = {state_i.control_high_digit, 3'b000}
                       + {2'b00, state_i.control_high_digit, 1'b0}
                       + {3'b000, state_i.control_low_digit};

  always_comb begin
    priority if (state_i.malformed_flag ||
                 (state_i.digit_count < scdv_pkg::TotalDigits)) begin
      fault_o = scdv_pkg::FAULT_MALFORMED;
    end else if (state_i.repeat_fault) begin
      fault_o = scdv_pkg::FAULT_REPEAT;
    end else if (control_pair != control_value) begin
      fault_o = scdv_pkg::FAULT_MISMATCH;
    end else begin
      fault_o = scdv_pkg::FAULT_NONE;
    end
  end

endmodule

FILE: rtl/snils_check_digit_validator_core.sv
// Path: an accepted item is held in the input register, and its verdict is written to the result
// register when the output is not stalled; only items marked with tlast produce a result.
// Throughput: one character item per cycle while the output is not stalled.
// Reset clears the input and result stages, the per-number state and sets the run
// threshold to 2; no clearing pass is needed.
module snils_check_digit_validator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,      // max_repeat_run
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_code
  input  logic       s_axis_tlast_i,   // end_of_number
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [0] number_valid, [2:1] fault_code, [7:3] zero
);

  logic       max_run_q;
  logic [3:0] max_run_val_q;
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       out_valid_q;
  scdv_pkg::fault_e fault_q;
  scdv_pkg::fault_e fault;
  scdv_pkg::number_state_t state_next;
  logic       advance;
  logic       step;

  assign advance         = !out_valid_q || m_axis_tready_i;
  assign step            = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_run_q     <= 1'b0;
      max_run_val_q <= scdv_pkg::RunReset;
    end else if (cfg_we_i) begin
      max_run_q     <= 1'b1;
      max_run_val_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  scdv_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .char_i    (in_char_q),
    .last_i    (in_last_q),
    .max_run_i (max_run_val_q),
    .state_o   (state_next)
  );

  scdv_verdict u_verdict (
    .state_i (state_next),
    .fault_o (fault)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && in_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_last_q) begin
      fault_q <= fault;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, fault_q, fault_q == scdv_pkg::FAULT_NONE};

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_char_q) && $stable(in_last_q))
    else $error("staged item lost while the output was stalled");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && in_last_q))
    else $error("result produced without a marked item");

  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> max_run_q && (max_run_val_q == $past(cfg_wdata_i)))
    else $error("run threshold not written");

endmodule
